// ===== rtl/core/acpe_pkg.sv =====
// shared constants, types and state codes of the autocorrelation pitch estimator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package acpe_pkg;

    localparam int FRAME_SAMPLES = 1024;
    localparam int PADDED        = FRAME_SAMPLES + FRAME_SAMPLES / 2;
    localparam int HALF          = PADDED / 2;

    localparam int SAMPLE_W = 16;
    localparam int RATE_W   = 18;
    localparam int PITCH_W  = 27;
    localparam int ADDR_W   = $clog2(FRAME_SAMPLES);
    localparam int CNT_W    = $clog2(FRAME_SAMPLES + 1);
    localparam int LAG_W    = $clog2(HALF);
    localparam int PAD_W    = $clog2(FRAME_SAMPLES + HALF);
    localparam int CORR_W   = 2 * SAMPLE_W + $clog2(FRAME_SAMPLES);
    localparam int TH_W     = CORR_W + 4;
    localparam int DIV_W    = 64;
    localparam int DCNT_W   = $clog2(DIV_W);

    localparam logic [RATE_W-1:0]  RATE_RESET = RATE_W'(44100);
    localparam logic [PITCH_W-1:0] PITCH_MAX  = {PITCH_W{1'b1}};
    localparam logic [LAG_W-1:0]   LAG_LAST   = LAG_W'(HALF - 1);
    localparam logic [LAG_W-1:0]   PEAK_LAST  = LAG_W'(HALF - 2);

    typedef enum logic [3:0] {
        B_IDLE,
        B_CORR,
        B_RISE,
        B_PEAK,
        B_FETCH,
        B_SETUP,
        B_QSTART,
        B_QWAIT,
        B_TP,
        B_PWAIT,
        B_DONE
    } back_state_t;

    typedef struct packed {
        logic                       we;
        logic [ADDR_W-1:0]          addr;
        logic signed [SAMPLE_W-1:0] data;
    } smp_wr_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
    } job_t;

endpackage

`default_nettype wire

// ===== rtl/core/autocorrelation_pitch_estimator.sv =====
// top level of the autocorrelation pitch estimator
// depends on acpe_pkg, acpe_front, acpe_queue, acpe_back (and acpe_div below it)
//
// usage:
//   s_axis carries one signed 16-bit sample per transfer in tdata, tlast closes the frame.
//   up to 1024 samples are kept per frame, later ones are dropped until tlast.
//   m_axis gives one transfer per frame: tdata holds the pitch in Q8 Hz, tuser the
//   peak-found flag. cfg_we with cfg_data sets the sample rate in Hz (reset 44100).
//   after tlast, s_axis_tready stays low while the frame is processed.
//   after tlast, the frame passes through multiply-accumulate (one product per cycle),
//     the rise search, the peak search, a fetch of the peak neighbours and up to two
//     divides in the 64-step divider (lag refinement and pitch).
//   a finished result sits in an output register; while m_axis_tready is low the
//   next frame can be loaded and processed, and its result waits for the register.
//   reset clears the sample count, the handshake state and restores the sample rate.
`timescale 1ns / 1ps
`default_nettype none

module autocorrelation_pitch_estimator (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [15:0]                 s_axis_tdata,  // sample
    input  wire logic                        s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [31:0]                      m_axis_tdata,  // pitch_q8, zero fill
    output logic                             m_axis_tuser,  // peak_found
    input  wire logic                        cfg_we,
    input  wire logic [acpe_pkg::RATE_W-1:0] cfg_data
);
    import acpe_pkg::*;

    logic [RATE_W-1:0]  rate_reg;
    smp_wr_t            smp_wr;
    logic               job_push;
    job_t               job_in;
    logic               job_ready;
    logic               job_pop;
    logic               job_valid;
    job_t               job_out;
    logic               back_done;
    logic [PITCH_W-1:0] pitch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= RATE_RESET;
        end
        else if (cfg_we)
        begin
            rate_reg <= cfg_data;
        end
    end

    acpe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_sample (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .smp_wr    (smp_wr),
        .job_push  (job_push),
        .job_data  (job_in),
        .job_ready (job_ready),
        .back_done (back_done)
    );

    acpe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_data  (job_in),
        .push_ready (job_ready),
        .pop        (job_pop),
        .pop_valid  (job_valid),
        .pop_data   (job_out)
    );

    acpe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_wr    (smp_wr),
        .job_valid (job_valid),
        .job_data  (job_out),
        .job_pop   (job_pop),
        .rate      (rate_reg),
        .done      (back_done),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_pitch (pitch),
        .out_found (m_axis_tuser)
    );

    assign m_axis_tdata = {(32 - PITCH_W)'(0), pitch};

endmodule

`default_nettype wire

// ===== rtl/core/acpe_div.sv =====
// shared restoring divider, one quotient bit per cycle
// depends on acpe_pkg
`timescale 1ns / 1ps
`default_nettype none

module acpe_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [acpe_pkg::DIV_W-1:0] dividend,
    input  wire logic [acpe_pkg::DIV_W-1:0] divisor,
    output logic                            done,
    output logic [acpe_pkg::DIV_W-1:0]      quotient
);
    import acpe_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DIV_W:0]    rem_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [DIV_W-1:0]  dvs_reg;
    logic [DIV_W:0]    rem_sh;
    logic              ge;

    assign rem_sh = {rem_reg[DIV_W-1:0], quo_reg[DIV_W-1]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == DCNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sh - {1'b0, dvs_reg} : rem_sh;
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/acpe_front.sv =====
// front end: takes sample transfers, places them in the sample memory, issues a job per frame
// depends on acpe_pkg
`timescale 1ns / 1ps
`default_nettype none

module acpe_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [acpe_pkg::SAMPLE_W-1:0] in_sample,
    input  wire logic                          in_last,
    output acpe_pkg::smp_wr_t                  smp_wr,
    output logic                               job_push,
    output acpe_pkg::job_t                     job_data,
    input  wire logic                          job_ready,
    input  wire logic                          back_done
);
    import acpe_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pending_reg;
    logic             pending_next;
    logic             accept;
    logic             room;

    assign in_ready = !pending_reg && job_ready;
    assign accept   = in_valid && in_ready;
    assign room     = count_reg < CNT_W'(FRAME_SAMPLES);

    assign smp_wr.we   = accept && room;
    assign smp_wr.addr = count_reg[ADDR_W-1:0];
    assign smp_wr.data = in_sample;

    assign job_push       = accept && in_last;
    assign job_data.count = room ? count_reg + 1'b1 : count_reg;

    always_comb
    begin
        count_next   = count_reg;
        pending_next = pending_reg;
        if (back_done)
        begin
            pending_next = 1'b0;
        end
        if (accept)
        begin
            if (in_last)
            begin
                count_next   = '0;
                pending_next = 1'b1;
            end
            else if (room)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            pending_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            pending_reg <= pending_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/acpe_queue.sv =====
// two-entry job queue between front end and back end
// depends on acpe_pkg
`timescale 1ns / 1ps
`default_nettype none

module acpe_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  acpe_pkg::job_t      push_data,
    output logic                push_ready,
    input  wire logic           pop,
    output logic                pop_valid,
    output acpe_pkg::job_t      pop_data
);
    import acpe_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] level_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = level_reg != 2'd2;
    assign pop_valid  = level_reg != 2'd0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                level_reg <= level_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/acpe_back.sv =====
// back end: sample and correlation memories, multiply-accumulate, peak search,
// parabolic refinement and pitch division; depends on acpe_pkg and acpe_div
`timescale 1ns / 1ps
`default_nettype none

module acpe_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  acpe_pkg::smp_wr_t                 smp_wr,
    input  wire logic                         job_valid,
    input  acpe_pkg::job_t                    job_data,
    output logic                              job_pop,
    input  wire logic [acpe_pkg::RATE_W-1:0]  rate,
    output logic                              done,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [acpe_pkg::PITCH_W-1:0]      out_pitch,
    output logic                              out_found
);
    import acpe_pkg::*;

    back_state_t state_reg, state_next;

    logic signed [SAMPLE_W-1:0] smp_mem [FRAME_SAMPLES];
    logic signed [CORR_W-1:0]   corr_mem [HALF];

    // job and issue counters
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0] n_reg, n_next;
    logic [LAG_W-1:0]  k_reg, k_next;
    logic [LAG_W-1:0]  i_reg, i_next;
    logic              iss_reg, iss_next;

    // correlation pipeline
    logic [PAD_W-1:0]  m_sum, m_wrap;
    logic [ADDR_W-1:0] m_addr;
    logic              corr_issue;
    logic              n_last;
    logic signed [SAMPLE_W-1:0] a_reg, b_reg;
    logic              v1_reg, f1_reg, l1_reg;
    logic [LAG_W-1:0]  k1_reg;
    logic signed [2*SAMPLE_W-1:0] prod_reg;
    logic              v2_reg, f2_reg, l2_reg;
    logic [LAG_W-1:0]  k2_reg;
    logic signed [CORR_W-1:0] acc_reg, acc_sum;
    logic              wr_en;

    // correlation read
    logic              rd_issue;
    logic [LAG_W-1:0]  rd_addr;
    logic signed [CORR_W-1:0] rdat_reg;
    logic              rv_reg, rv_next;
    logic [LAG_W-1:0]  ri_reg;
    logic              iss_last;

    // search
    logic signed [CORR_W-1:0] prev_reg, r0_reg, low_val;
    logic [LAG_W-1:0]  low_idx;
    logic              rise_hit, rise_end;
    logic signed [TH_W-1:0] r4, r5, thr_reg, thr_next;
    logic              peak_upd;
    logic [LAG_W-1:0]  x_reg, x_next;

    // refinement
    logic signed [CORR_W-1:0] y0_reg, y1_reg, y2_reg;
    logic signed [TH_W-1:0]   d_reg;
    logic signed [DIV_W-1:0]  num_reg;
    logic                     neg_reg;
    logic signed [DIV_W-1:0]  tp_reg, tp_next;
    logic signed [DIV_W-1:0]  q_signed;
    logic signed [DIV_W-1:0]  x_q16;

    // divider
    logic             div_start;
    logic [DIV_W-1:0] div_a, div_b, div_q;
    logic             div_done;

    logic [PITCH_W-1:0] res_pitch_reg, res_pitch_next;
    logic               res_found_reg, res_found_next;
    logic               out_valid_reg;
    logic [PITCH_W-1:0] out_pitch_reg;
    logic               out_found_reg;
    logic               out_load;

    // correlation address generation
    assign m_sum  = PAD_W'(n_reg) + PAD_W'(k_reg);
    assign m_wrap = (m_sum >= PAD_W'(PADDED)) ? m_sum - PAD_W'(PADDED) : m_sum;
    assign m_addr = m_wrap[ADDR_W-1:0];
    assign corr_issue = (state_reg == B_CORR) && iss_reg;
    assign n_last = CNT_W'(n_reg) == cnt_reg - 1'b1;

    assign acc_sum = (f2_reg ? CORR_W'(0) : acc_reg)
                   + (v2_reg ? CORR_W'(prod_reg) : CORR_W'(0));
    assign wr_en   = v2_reg || l2_reg ? l2_reg : 1'b0;

    always_ff @(posedge clk)
    begin
        if (smp_wr.we)
        begin
            smp_mem[smp_wr.addr] <= smp_wr.data;
        end
        a_reg <= smp_mem[n_reg];
        b_reg <= smp_mem[m_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            corr_mem[k2_reg] <= acc_sum;
        end
        rdat_reg <= corr_mem[rd_addr];
    end

    // search and fetch reads
    assign rd_addr  = i_reg;
    assign rd_issue = iss_reg && ((state_reg == B_RISE) || (state_reg == B_PEAK)
                                  || (state_reg == B_FETCH));
    always_comb
    begin
        unique case (state_reg)
            B_RISE:  iss_last = i_reg == LAG_LAST;
            B_PEAK:  iss_last = i_reg == PEAK_LAST;
            B_FETCH: iss_last = i_reg == x_reg + 1'b1;
            default: iss_last = 1'b1;
        endcase
    end

    assign rise_hit = (state_reg == B_RISE) && rv_reg && (ri_reg >= LAG_W'(2))
                      && (rdat_reg > prev_reg);
    assign rise_end = (state_reg == B_RISE) && rv_reg && (ri_reg == LAG_LAST) && !rise_hit;
    assign low_idx  = rise_hit ? ri_reg - 1'b1 : '0;
    assign low_val  = rise_hit ? prev_reg : r0_reg;

    assign r4 = TH_W'(rdat_reg) <<< 2;
    assign r5 = r4 + TH_W'(rdat_reg);
    assign peak_upd = (state_reg == B_PEAK) && rv_reg && (r4 > thr_reg);

    assign x_q16    = DIV_W'(x_reg) << 16;
    assign q_signed = neg_reg ? -$signed(div_q) : $signed(div_q);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = B_CORR;
                end
            end
            B_CORR:
            begin
                if (wr_en && (k2_reg == LAG_LAST))
                begin
                    state_next = B_RISE;
                end
            end
            B_RISE:
            begin
                if (rise_hit || rise_end)
                begin
                    state_next = B_PEAK;
                end
            end
            B_PEAK:
            begin
                if (rv_reg && (ri_reg == PEAK_LAST))
                begin
                    state_next = B_FETCH;
                end
            end
            B_FETCH:
            begin
                if (x_reg == '0)
                begin
                    state_next = B_DONE;
                end
                else if (rv_reg && (ri_reg == x_reg + 1'b1))
                begin
                    state_next = B_SETUP;
                end
            end
            B_SETUP:  state_next = B_QSTART;
            B_QSTART: state_next = (d_reg == '0) ? B_TP : B_QWAIT;
            B_QWAIT:
            begin
                if (div_done)
                begin
                    state_next = B_TP;
                end
            end
            B_TP:
            begin
                if ((tp_reg == '0) || tp_reg[DIV_W-1])
                begin
                    state_next = B_DONE;
                end
                else
                begin
                    state_next = B_PWAIT;
                end
            end
            B_PWAIT:
            begin
                if (div_done)
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // outputs and datapath next values
    always_comb
    begin
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        iss_next       = iss_reg;
        rv_next        = rd_issue;
        thr_next       = thr_reg;
        x_next         = x_reg;
        tp_next        = tp_reg;
        res_pitch_next = res_pitch_reg;
        res_found_next = res_found_reg;
        job_pop        = 1'b0;
        div_start      = 1'b0;
        div_a          = DIV_W'(rate) << 24;
        div_b          = tp_reg;
        out_load       = 1'b0;
        done           = 1'b0;

        if (rd_issue)
        begin
            i_next = i_reg + 1'b1;
            if (iss_last)
            begin
                iss_next = 1'b0;
            end
        end

        unique case (state_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop  = 1'b1;
                    cnt_next = job_data.count;
                    n_next   = '0;
                    k_next   = '0;
                    iss_next = 1'b1;
                end
            end
            B_CORR:
            begin
                if (corr_issue)
                begin
                    if (n_last)
                    begin
                        n_next = '0;
                        if (k_reg == LAG_LAST)
                        begin
                            iss_next = 1'b0;
                        end
                        else
                        begin
                            k_next = k_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        n_next = n_reg + 1'b1;
                    end
                end
                if (wr_en && (k2_reg == LAG_LAST))
                begin
                    i_next   = '0;
                    iss_next = 1'b1;
                end
            end
            B_RISE:
            begin
                if (rise_hit || rise_end)
                begin
                    i_next   = low_idx;
                    iss_next = 1'b1;
                    rv_next  = 1'b0;
                    thr_next = TH_W'(low_val) <<< 2;
                    x_next   = '0;
                end
            end
            B_PEAK:
            begin
                if (peak_upd)
                begin
                    thr_next = r5;
                    x_next   = ri_reg;
                end
                if (rv_reg && (ri_reg == PEAK_LAST))
                begin
                    i_next   = (peak_upd ? ri_reg : x_reg) - 1'b1;
                    iss_next = 1'b1;
                    rv_next  = 1'b0;
                end
            end
            B_FETCH:
            begin
                if (x_reg == '0)
                begin
                    res_pitch_next = '0;
                    res_found_next = 1'b0;
                    iss_next       = 1'b0;
                end
            end
            B_SETUP:
            begin
            end
            B_QSTART:
            begin
                if (d_reg == '0)
                begin
                    tp_next = x_q16;
                end
                else
                begin
                    div_start = 1'b1;
                    div_a     = num_reg[DIV_W-1] ? DIV_W'(-num_reg) : DIV_W'(num_reg);
                    div_b     = d_reg[TH_W-1] ? DIV_W'(-d_reg) : DIV_W'(d_reg);
                end
            end
            B_QWAIT:
            begin
                if (div_done)
                begin
                    tp_next = x_q16 + q_signed;
                end
            end
            B_TP:
            begin
                if (tp_reg == '0)
                begin
                    res_pitch_next = '0;
                    res_found_next = 1'b0;
                end
                else if (tp_reg[DIV_W-1])
                begin
                    res_pitch_next = '0;
                    res_found_next = 1'b1;
                end
                else
                begin
                    div_start = 1'b1;
                end
            end
            B_PWAIT:
            begin
                if (div_done)
                begin
                    res_found_next = 1'b1;
                    res_pitch_next = (div_q > DIV_W'(PITCH_MAX)) ? PITCH_MAX
                                                                  : div_q[PITCH_W-1:0];
                end
            end
            B_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load = 1'b1;
                    done     = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            iss_reg       <= 1'b0;
            rv_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            l1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            l2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iss_reg   <= iss_next;
            rv_reg    <= rv_next;
            v1_reg    <= corr_issue && (m_wrap < PAD_W'(cnt_reg));
            l1_reg    <= corr_issue && n_last;
            v2_reg    <= v1_reg;
            l2_reg    <= l1_reg;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        n_reg         <= n_next;
        k_reg         <= k_next;
        i_reg         <= i_next;
        ri_reg        <= i_reg;
        f1_reg        <= n_reg == '0;
        k1_reg        <= k_reg;
        prod_reg      <= a_reg * b_reg;
        f2_reg        <= f1_reg;
        k2_reg        <= k1_reg;
        acc_reg       <= acc_sum;
        thr_reg       <= thr_next;
        x_reg         <= x_next;
        tp_reg        <= tp_next;
        res_pitch_reg <= res_pitch_next;
        res_found_reg <= res_found_next;
        if (rv_reg)
        begin
            prev_reg <= rdat_reg;
            if ((state_reg == B_RISE) && (ri_reg == '0))
            begin
                r0_reg <= rdat_reg;
            end
            if (state_reg == B_FETCH)
            begin
                if (ri_reg == x_reg - 1'b1)
                begin
                    y0_reg <= rdat_reg;
                end
                if (ri_reg == x_reg)
                begin
                    y1_reg <= rdat_reg;
                end
                if (ri_reg == x_reg + 1'b1)
                begin
                    y2_reg <= rdat_reg;
                end
            end
        end
        if (state_reg == B_SETUP)
        begin
            d_reg   <= TH_W'(y0_reg) - (TH_W'(y1_reg) <<< 1) + TH_W'(y2_reg);
            num_reg <= (DIV_W'(y0_reg) - DIV_W'(y2_reg)) <<< 15;
        end
        if (state_reg == B_QSTART)
        begin
            neg_reg <= num_reg[DIV_W-1] ^ d_reg[TH_W-1];
        end
        if (out_load)
        begin
            out_pitch_reg <= res_pitch_reg;
            out_found_reg <= res_found_reg;
        end
    end

    acpe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_valid = out_valid_reg;
    assign out_pitch = out_pitch_reg;
    assign out_found = out_found_reg;

endmodule

`default_nettype wire

// ===== dv/autocorrelation_pitch_estimator_tb.sv =====
// self-checking testbench for autocorrelation_pitch_estimator: frames of samples in,
// one pitch result per frame out, checked against an in-bench pitch predictor
// depends on acpe_pkg and the autocorrelation_pitch_estimator rtl
`timescale 1ns / 1ps

module autocorrelation_pitch_estimator_tb;
    import acpe_pkg::*;

    typedef struct {
        logic [PITCH_W-1:0] pitch;
        logic               found;
    } pitch_result_t;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata;
    logic              s_axis_tlast;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [31:0]       m_axis_tdata;
    logic              m_axis_tuser;
    logic              cfg_we;
    logic [RATE_W-1:0] cfg_data;

    pitch_result_t     pending_pitch[$];
    shortint           frame_buf[FRAME_SAMPLES];
    int                frame_len;
    logic [RATE_W-1:0] rate_hz;
    int                errors;
    bit                quiet;
    bit                hold_req;

    autocorrelation_pitch_estimator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(64'd250_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic pitch_result_t estimate_pitch();
        longint        corr[HALF];
        longint        acc, thr4, y0, y1, y2, den, lag_q16, hz;
        int            m, low, x;
        pitch_result_t res;
        for (int k = 0; k < HALF; k++)
        begin
            acc = 0;
            for (int n = 0; n < frame_len; n++)
            begin
                m = (n + k) % PADDED;
                if (m < frame_len)
                    acc += longint'(frame_buf[n]) * longint'(frame_buf[m]);
            end
            corr[k] = acc;
        end
        low = 0;
        x = 0;
        for (int i = 2; i < HALF; i++)
        begin
            if (corr[i] > corr[i-1])
            begin
                low = i - 1;
                break;
            end
        end
        thr4 = 4 * corr[low];
        for (int i = low; i < HALF - 1; i++)
        begin
            if (4 * corr[i] > thr4)
            begin
                thr4 = 5 * corr[i];
                x = i;
            end
        end
        res.pitch = '0;
        res.found = 1'b0;
        if (x < 1)
            return res;
        y0 = corr[x-1];
        y1 = corr[x];
        y2 = corr[x+1];
        den = y0 - 2 * y1 + y2;
        lag_q16 = longint'(x) * 65536;
        if (den != 0)
            lag_q16 += ((y0 - y2) * 32768) / den;
        if (lag_q16 == 0)
            return res;
        res.found = 1'b1;
        if (lag_q16 < 0)
            return res;
        hz = (longint'(rate_hz) * 16777216) / lag_q16;
        if (hz > longint'(PITCH_MAX))
            hz = longint'(PITCH_MAX);
        res.pitch = PITCH_W'(hz);
        return res;
    endfunction

    // one sample transfer; leaves time at the accepting rising edge or after a gap
    task automatic send_sample(input shortint smp, input bit last);
        int gap;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (frame_len < FRAME_SAMPLES)
        begin
            frame_buf[frame_len] = smp;
            frame_len++;
        end
        if (last)
        begin
            pending_pitch.push_back(estimate_pitch());
            frame_len = 0;
        end
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 15);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_all_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (pending_pitch.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_rate(input logic [RATE_W-1:0] hz);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= hz;
        @(negedge clk);
        cfg_we   <= 1'b0;
        rate_hz = hz;
    endtask

    // pulse train of given period, with optional noise
    task automatic send_periodic(input int len, input int period, input shortint amp,
                                 input int noise);
        shortint v;
        for (int n = 0; n < len; n++)
        begin
            v = (n % period == 0) ? amp : shortint'(-(amp / period));
            if (noise > 0)
                v = shortint'(int'(v) + $urandom_range(0, 2 * noise) - noise);
            send_sample(v, n == len - 1);
        end
    endtask

    task automatic test_single_sample();
        send_sample(-16'sd32768, 1'b1);
        send_sample(16'sd32767, 1'b1);
        send_sample(16'sd0, 1'b1);
    endtask

    task automatic test_flat_frame();
        for (int n = 0; n < 6; n++)
            send_sample(16'sd0, n == 5);
        send_periodic(4, 1, 16'sd1000, 0);
    endtask

    task automatic test_periodic();
        send_periodic(9, 3, 16'sd32767, 0);
        send_periodic(8, 4, -16'sd32768, 0);
    endtask

    task automatic test_rate_extremes();
        write_rate(RATE_W'(1));
        send_periodic(10, 4, 16'sd20000, 300);
        wait_all_results();
        write_rate(RATE_W'(192000));
        send_periodic(10, 2, 16'sd30000, 0);
        wait_all_results();
        write_rate(RATE_W'(8000));
    endtask

    task automatic test_overlong_frame();
        for (int n = 0; n < FRAME_SAMPLES + 6; n++)
            send_sample(shortint'($urandom), n == FRAME_SAMPLES + 5);
        wait_all_results();
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int f = 0; f < 4; f++)
            send_periodic(3, 2, shortint'($urandom), 50);
        wait_all_results();
    endtask

    task automatic test_random_frames(input int items);
        int sent, len, kind;
        sent = 0;
        while (sent < items)
        begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 10);
            kind = $urandom_range(0, 3);
            if (kind == 0)
            begin
                for (int n = 0; n < len; n++)
                    send_sample(shortint'($urandom), n == len - 1);
            end
            else
                send_periodic(len, $urandom_range(2, 6), shortint'($urandom),
                              $urandom_range(0, 2000));
            sent += len;
            if (sent >= items / 2 && rate_hz == RATE_W'(8000))
            begin
                wait_all_results();
                write_rate(RATE_W'($urandom_range(1, 192000)));
            end
        end
    endtask

    initial
    begin
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (20000) @(negedge clk);
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 14)) @(negedge clk);
            end
            else
            begin
                @(negedge clk);
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(0, 20)) @(negedge clk);
            end
        end
    end

    initial
    begin
        pitch_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (pending_pitch.size() == 0)
                begin
                    $display("%0t: unexpected transfer tdata=%0h tuser=%0b",
                             $time, m_axis_tdata, m_axis_tuser);
                    errors++;
                end
                else
                begin
                    want = pending_pitch.pop_front();
                    if (m_axis_tdata !== {5'b0, want.pitch})
                    begin
                        $display("%0t: pitch_q8 expected %0d actual %0d",
                                 $time, want.pitch, m_axis_tdata);
                        errors++;
                    end
                    if (m_axis_tuser !== want.found)
                    begin
                        $display("%0t: peak_found expected %0b actual %0b",
                                 $time, want.found, m_axis_tuser);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        errors = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        frame_len = 0;
        rate_hz = RATE_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_single_sample();
        test_flat_frame();
        test_periodic();
        wait_all_results();
        test_rate_extremes();
        test_overlong_frame();
        test_backpressure();
        test_random_frames(150);
        quiet = 1'b1;
        test_random_frames(60);
        wait_all_results();
        repeat (200) @(posedge clk);

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
